/* hw/rtl/tslf_pkg.sv */
package tslf_pkg;

    localparam int unsigned BUFFER_DEPTH_DEF = 256;

    localparam int unsigned THRESH_W   = 18;
    localparam int unsigned TEMP_W     = 19;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 24;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 18'd80000;

    // x / 100 as (x * 20972) >> 21, exact for x below 43690
    localparam int unsigned DIFF_W       = 21;
    localparam int unsigned QUOT_IN_W    = 15;
    localparam int unsigned RECIP_SHIFT  = 21;
    localparam logic [QUOT_IN_W-1:0] RECIP_MUL   = 15'd20972;
    localparam logic [DIFF_W-1:0]    ROUND_OFFSET = 21'd50;
    localparam logic [DIFF_W-2:0]    CLAMP_LIMIT  = 20'd25600;
    localparam logic [BYTE_W-1:0]    BYTE_MAX     = 8'd255;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [BYTE_W-1:0] fill_count;
        logic              log_full;
        logic              logging_armed;
        logic [BYTE_W-1:0] read_byte;
    } t_result;

endpackage

/* hw/rtl/triggered_sample_logger_fifo.sv */
// Triggered sample logger with a byte FIFO. Each request on the slave stream is either a sample
// tick (tuser 0, tdata = signed temperature in millidegrees) or a read (tuser 1), and gives exactly
// one result on the master stream in the cycle after it is taken: read_valid in tuser, and in tdata
// the popped byte, the armed and full flags and the saturated fill count. A request is taken in
// every cycle in which the output register is empty or being emptied, so throughput is one request
// per cycle; the log store is a single memory with one write and one registered read per cycle,
// which sets that rate. The FIFO holds up to BUFFER_DEPTH-1 bytes and needs no clearing pass after
// reset. The start threshold is written through the cfg channel, which is always ready and should
// only be used while the stream is idle.
module triggered_sample_logger_fifo #(
    parameter int unsigned BUFFER_DEPTH = tslf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tslf_pkg::THRESH_W-1:0]      i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tslf_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [18:0] temp_millideg
    input  logic                               s_axis_tuser,  // [0] opcode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tslf_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [7:0] read_byte, [8] logging_armed,
                                                              // [9] log_full, [17:10] fill_count
    output logic                               m_axis_tuser   // [0] read_valid
);
    import tslf_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned XW = (AW > BYTE_W) ? AW : BYTE_W;

    logic [THRESH_W-1:0] r_thresh;
    logic                r_armed, n_armed;
    logic                r_full, n_full;
    logic [AW-1:0]       r_wptr, n_wptr;
    logic [AW-1:0]       r_rptr, n_rptr;
    logic [AW-1:0]       r_count, n_count;
    logic                r_out_valid;
    logic                r_rv;
    logic                r_armed_q;
    logic                r_full_q;
    logic [BYTE_W-1:0]   r_fill_q;
    logic [BYTE_W-1:0]   r_mem_q;
    logic [BYTE_W-1:0]   r_mem [BUFFER_DEPTH];

    logic                accept;
    logic                wr_en;
    logic                rd_en;
    t_opcode             op;
    logic [TEMP_W-1:0]   temp;
    logic [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]   x;
    logic [2*QUOT_IN_W-1:0] prod;
    logic [BYTE_W-1:0]   tenths;
    logic [XW-1:0]       count_x;
    logic [BYTE_W-1:0]   fill_sat;
    t_result             res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = t_opcode'(s_axis_tuser);
    assign temp          = s_axis_tdata[TEMP_W-1:0];

    always_comb begin
        diff = {{(DIFF_W-TEMP_W){temp[TEMP_W-1]}}, temp}
             - {{(DIFF_W-THRESH_W){1'b0}}, r_thresh};
        x    = diff + ROUND_OFFSET;
        prod = x[QUOT_IN_W-1:0] * RECIP_MUL;
        if (x[DIFF_W-1] || x == '0) begin
            tenths = '0;
        end else if (x[DIFF_W-2:0] >= CLAMP_LIMIT) begin
            tenths = BYTE_MAX;
        end else begin
            tenths = prod[RECIP_SHIFT +: BYTE_W];
        end
    end

    always_comb begin
        n_armed = r_armed;
        n_full  = r_full;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        case (op)
            OP_TICK: begin
                if (!r_full) begin
                    if (r_armed) begin
                        if (r_count < AW'(BUFFER_DEPTH - 1)) begin
                            wr_en   = 1'b1;
                            n_wptr  = (r_wptr == AW'(BUFFER_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_full = 1'b1;
                        end
                    end else if (!diff[DIFF_W-1] && diff != '0) begin
                        n_armed = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (r_count != '0) begin
                    rd_en   = 1'b1;
                    n_rptr  = (r_rptr == AW'(BUFFER_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
        count_x  = XW'(n_count);
        fill_sat = (count_x > XW'(BYTE_MAX)) ? BYTE_MAX : count_x[BYTE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_armed     <= 1'b0;
            r_full      <= 1'b0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
            if (accept) begin
                r_armed     <= n_armed;
                r_full      <= n_full;
                r_wptr      <= n_wptr;
                r_rptr      <= n_rptr;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rv      <= rd_en;
            r_armed_q <= n_armed;
            r_full_q  <= n_full;
            r_fill_q  <= fill_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[r_wptr] <= tenths;
        end
        if (accept) begin
            r_mem_q <= r_mem[r_rptr];
        end
    end

    always_comb begin
        res.fill_count    = r_fill_q;
        res.log_full      = r_full_q;
        res.logging_armed = r_armed_q;
        res.read_byte     = r_rv ? r_mem_q : '0;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_rv;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, res};

endmodule

/* hw/rtl/tslf_chk.sv */
module tslf_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tslf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);
    import tslf_pkg::*;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("request taken without a result next cycle");

    a_full_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[BYTE_W+1] |-> m_axis_tdata[BYTE_W])
        else $error("log full reported while not armed");

    a_empty_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[BYTE_W-1:0] == '0)
        else $error("read byte non-zero without read_valid");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind triggered_sample_logger_fifo tslf_chk u_tslf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
